[design/lz10_pkg.sv]
// ----------------------------------------------------------------------------
// lz10_pkg
// Types and constants shared by the LZ type-10 stream decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lz10_pkg;

  typedef enum logic [6:0] {
    PH_SKIP  = 7'b0000001,
    PH_MAGIC = 7'b0000010,
    PH_LEN   = 7'b0000100,
    PH_FLAG  = 7'b0001000,
    PH_TOKEN = 7'b0010000,
    PH_REFLO = 7'b0100000,
    PH_DONE  = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    C_IN   = 2'b01,
    C_COPY = 2'b10
  } ctl_t;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_MAGIC = 2'd1;
  localparam logic [1:0] KIND_REF   = 2'd2;

  localparam logic CFG_SKIP_IDX  = 1'b0;
  localparam logic CFG_MAGIC_IDX = 1'b1;

  localparam logic [7:0] MAGIC_RESET = 8'h10;
  localparam int         MIN_MATCH   = 3;
  localparam logic [3:0] TOKENS_PER_FLAG = 4'd8;
  localparam logic [2:0] SKIP_BYTES  = 3'd4;
  localparam logic [2:0] LEN_BYTES   = 3'd3;

endpackage : lz10_pkg

`default_nettype wire

[design/lz10_ram.sv]
// ----------------------------------------------------------------------------
// lz10_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lz10_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : lz10_ram

`default_nettype wire

[design/lz10_stream_decompressor.sv]
// ----------------------------------------------------------------------------
// lz10_stream_decompressor
// LZ type-10 decompressor that takes one compressed byte per word.
// ----------------------------------------------------------------------------
// Header, length, flag, literal and the first byte of a reference each take one
// input word. The second byte of a reference starts a copy of 3 to 18 bytes from
// the history memory, and no new word is taken until the copy ends. A copy
// cut short by the declared length ends early. The copy rate is set by the
// single read port of the history memory; output backpressure stalls the copy.
// Results are held in one output register, and a new word is taken only while
// that register is free or being emptied. History entries are only read after
// being written in the current stream, so the history memory needs no clearing
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lz10_stream_decompressor
  import lz10_pkg::*;
#(
  parameter int WINDOW_DEPTH = 4096,
  parameter int MAX_RUN      = 18
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Fields from bit 0: data_byte.
  input  wire logic [7:0] in_tdata,
  // Fields from bit 0: start_req.
  input  wire logic       in_tuser,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  // Fields from bit 0: out_byte.
  output logic [7:0]      out_tdata,
  // Fields from bit 0: kind (2 bits), stream_done.
  output logic [2:0]      out_tuser,
  output logic            out_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int PW = AW + 1;
  localparam int RW = $clog2(MAX_RUN + 1);

  logic          skip_r;
  logic [7:0]    magic_r;
  ctl_t          ctl_r, ctl_nxt;
  phase_t        ph_r, ph_nxt, ph_c;
  logic [2:0]    hc_r, hc_nxt, hc_c;
  logic [7:0]    flag_r, flag_nxt, flag_c;
  logic [3:0]    tok_r, tok_nxt, tok_c;
  logic [23:0]   rem_r, rem_nxt, rem_c;
  logic [PW-1:0] prod_r, prod_nxt, prod_c;
  logic [7:0]    rh_r, rh_nxt, rh_c;
  logic          halt_r, halt_nxt, halt_c;
  logic [AW-1:0] wp_r, wp_nxt, wp_c;
  logic [AW-1:0] dist_r, dist_nxt;
  logic [RW-1:0] run_r, run_nxt;

  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic [1:0]    out_kind_r;
  logic          out_last_r;
  logic          out_done_r;

  logic          ld;
  logic [7:0]    ld_byte;
  logic [1:0]    ld_kind;
  logic          ld_last;
  logic          ld_done;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_q;
  logic          fwd_r;
  logic [7:0]    fwd_data_r;
  logic [7:0]    hist_byte;

  logic          out_free;
  logic          acc;
  logic [12:0]   dist_full;
  logic [RW-1:0] run_len;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (ctl_r == C_IN) && out_free;
  assign acc       = in_tvalid && in_tready;
  assign hist_byte = fwd_r ? fwd_data_r : ram_q;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_done_r, out_kind_r};
  assign out_tlast  = out_last_r;

  always_comb begin
    ph_c   = ph_r;
    hc_c   = hc_r;
    flag_c = flag_r;
    tok_c  = tok_r;
    rem_c  = rem_r;
    prod_c = prod_r;
    rh_c   = rh_r;
    halt_c = halt_r;
    wp_c   = wp_r;
    if (acc && in_tuser) begin
      ph_c   = skip_r ? PH_SKIP : PH_MAGIC;
      hc_c   = '0;
      flag_c = '0;
      tok_c  = '0;
      rem_c  = '0;
      prod_c = '0;
      rh_c   = '0;
      halt_c = 1'b0;
      wp_c   = '0;
    end

    ctl_nxt  = ctl_r;
    ph_nxt   = ph_c;
    hc_nxt   = hc_c;
    flag_nxt = flag_c;
    tok_nxt  = tok_c;
    rem_nxt  = rem_c;
    prod_nxt = prod_c;
    rh_nxt   = rh_c;
    halt_nxt = halt_c;
    wp_nxt   = wp_c;
    dist_nxt = dist_r;
    run_nxt  = run_r;

    ld      = 1'b0;
    ld_byte = '0;
    ld_kind = KIND_DATA;
    ld_last = 1'b0;
    ld_done = 1'b0;

    ram_we    = 1'b0;
    ram_waddr = wp_c;
    ram_wdata = in_tdata;
    ram_re    = 1'b0;
    ram_raddr = '0;

    dist_full = {1'b0, rh_c[3:0], in_tdata} + 13'd1;
    run_len   = RW'(rh_c[7:4]) + RW'(MIN_MATCH);

    if (acc && !halt_c) begin
      case (ph_c)
        PH_SKIP: begin
          hc_nxt = hc_c + 3'd1;
          if (hc_nxt == SKIP_BYTES) begin
            hc_nxt = '0;
            ph_nxt = PH_MAGIC;
          end
        end
        PH_MAGIC: begin
          if (in_tdata != magic_r) begin
            ld       = 1'b1;
            ld_kind  = KIND_MAGIC;
            ld_last  = 1'b1;
            halt_nxt = 1'b1;
          end else begin
            hc_nxt  = '0;
            rem_nxt = '0;
            ph_nxt  = PH_LEN;
          end
        end
        PH_LEN: begin
          case (hc_c[1:0])
            2'd0:    rem_nxt[7:0]   = in_tdata;
            2'd1:    rem_nxt[15:8]  = in_tdata;
            default: rem_nxt[23:16] = in_tdata;
          endcase
          hc_nxt = hc_c + 3'd1;
          if (hc_nxt == LEN_BYTES) begin
            hc_nxt = '0;
            ph_nxt = (rem_nxt != '0) ? PH_FLAG : PH_DONE;
          end
        end
        PH_FLAG: begin
          flag_nxt = in_tdata;
          tok_nxt  = TOKENS_PER_FLAG;
          ph_nxt   = PH_TOKEN;
        end
        PH_TOKEN: begin
          if (flag_c[7]) begin
            rh_nxt = in_tdata;
            ph_nxt = PH_REFLO;
          end else begin
            ld      = 1'b1;
            ld_byte = in_tdata;
            ld_last = 1'b1;
            ram_we  = 1'b1;
            wp_nxt  = wp_c + AW'(1);
            if (prod_c < PW'(WINDOW_DEPTH)) begin
              prod_nxt = prod_c + PW'(1);
            end
            rem_nxt = rem_c - 24'd1;
            ld_done = (rem_nxt == '0);
            if (ld_done) begin
              ph_nxt = PH_DONE;
            end else begin
              tok_nxt  = tok_c - 4'd1;
              flag_nxt = {flag_c[6:0], 1'b0};
              ph_nxt   = (tok_nxt == '0) ? PH_FLAG : PH_TOKEN;
            end
          end
        end
        PH_REFLO: begin
          if (PW'(dist_full) > prod_c) begin
            ld       = 1'b1;
            ld_kind  = KIND_REF;
            ld_last  = 1'b1;
            halt_nxt = 1'b1;
          end else begin
            ctl_nxt   = C_COPY;
            dist_nxt  = dist_full[AW-1:0];
            run_nxt   = run_len;
            ram_re    = 1'b1;
            ram_raddr = wp_c - dist_full[AW-1:0];
          end
        end
        default: begin
        end
      endcase
    end else if (ctl_r == C_COPY && out_free) begin
      ld        = 1'b1;
      ld_byte   = hist_byte;
      ram_we    = 1'b1;
      ram_waddr = wp_r;
      ram_wdata = hist_byte;
      wp_nxt    = wp_r + AW'(1);
      if (prod_r < PW'(WINDOW_DEPTH)) begin
        prod_nxt = prod_r + PW'(1);
      end
      rem_nxt = rem_r - 24'd1;
      run_nxt = run_r - RW'(1);
      ld_done = (rem_nxt == '0);
      ld_last = ld_done || (run_nxt == '0);
      if (ld_last) begin
        ctl_nxt = C_IN;
        if (ld_done) begin
          ph_nxt = PH_DONE;
        end else begin
          tok_nxt  = tok_r - 4'd1;
          flag_nxt = {flag_r[6:0], 1'b0};
          ph_nxt   = (tok_nxt == '0) ? PH_FLAG : PH_TOKEN;
        end
      end else begin
        ram_re    = 1'b1;
        ram_raddr = wp_nxt - dist_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r      <= 1'b0;
      magic_r     <= MAGIC_RESET;
      ctl_r       <= C_IN;
      ph_r        <= PH_MAGIC;
      hc_r        <= '0;
      flag_r      <= '0;
      tok_r       <= '0;
      rem_r       <= '0;
      prod_r      <= '0;
      rh_r        <= '0;
      halt_r      <= 1'b1;
      wp_r        <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SKIP_IDX) begin
          skip_r <= cfg_wdata[0];
        end
        if (cfg_index == CFG_MAGIC_IDX) begin
          magic_r <= cfg_wdata;
        end
      end
      ctl_r  <= ctl_nxt;
      ph_r   <= ph_nxt;
      hc_r   <= hc_nxt;
      flag_r <= flag_nxt;
      tok_r  <= tok_nxt;
      rem_r  <= rem_nxt;
      prod_r <= prod_nxt;
      rh_r   <= rh_nxt;
      halt_r <= halt_nxt;
      wp_r   <= wp_nxt;
      run_r  <= run_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    if (ld) begin
      out_byte_r <= ld_byte;
      out_kind_r <= ld_kind;
      out_last_r <= ld_last;
      out_done_r <= ld_done;
    end
    if (ram_re) begin
      fwd_r      <= ram_we && (ram_raddr == ram_waddr);
      fwd_data_r <= ram_wdata;
    end
  end

  lz10_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r == C_COPY) |-> (run_r != '0) && (run_r <= RW'(MAX_RUN)))
    else $error("Copy run count out of range.");

  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && ld_kind != KIND_DATA) |=> halt_r)
    else $error("Error result did not halt the stream.");

  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && ld_done) |=> (ph_r == PH_DONE) && (ctl_r == C_IN))
    else $error("Stream completion did not close the stream.");

  a_write_emits: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ld && (ld_kind == KIND_DATA))
    else $error("History written without a data word.");

  a_err_no_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1:0] != KIND_DATA) |-> !out_tuser[2] && out_tlast)
    else $error("Error word carries completion or misses last.");

endmodule : lz10_stream_decompressor

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the LZ type-10 stream decompressor.
// ----------------------------------------------------------------------------
// A queue of compressed words feeds a handshaking driver. Every accepted word
// goes through a local decoder model, which queues the output words it should
// cause. A monitor compares each output word with the oldest queued one. The
// stimulus opens with hand-built streams for the corner cases. Random streams
// follow under four register settings, some of them with long copies. Both
// sides stall at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  import lz10_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int WINDOW      = 4096;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] value;
    logic [1:0] kind;
    logic       last;
    logic       done;
  } out_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tuser = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       out_tlast;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;

  lz10_stream_decompressor uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder model state and its copy of the registers.
  logic        skip_hdr = 1'b0;
  logic [7:0]  magic = MAGIC_RESET;
  logic [7:0]  window [0:WINDOW-1];
  phase_t      ph = PH_MAGIC;
  logic [2:0]  hdr_cnt = '0;
  logic [7:0]  flag_bits = '0;
  logic [3:0]  tok_left = '0;
  logic [23:0] remaining = '0;
  logic [12:0] produced = '0;
  logic [7:0]  ref_hi = '0;
  logic        halted = 1'b1;
  logic [11:0] wr_ptr = '0;

  out_word_t   expect_q[$];
  in_word_t    pending_q[$];
  in_word_t    next_w;
  out_word_t   exp_w;

  int words_queued = 0;
  int words_accepted = 0;
  int words_out = 0;
  int gen_words = 0;
  int cut_left = -1;
  bit tally = 1'b1;
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_cnt = 0;
  logic send_idle = 1'b0;
  logic recv_idle = 1'b0;
  logic hold_on = 1'b0;

  int n_streams = 0;
  int n_done = 0;
  int n_empty = 0;
  int n_bad_type = 0;
  int n_early_ref = 0;
  int n_copies = 0;

  function automatic bit emit_byte(input logic [7:0] b);
    out_word_t r;
    window[wr_ptr] = b;
    wr_ptr = wr_ptr + 12'd1;
    if (produced < 13'(WINDOW)) produced = produced + 13'd1;
    remaining = remaining - 24'd1;
    r.value = b;
    r.kind = KIND_DATA;
    r.last = 1'b0;
    r.done = (remaining == 24'd0);
    expect_q.insert(expect_q.size(), r);
    if (remaining == 24'd0) begin
      ph = PH_DONE;
      n_done++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void next_token();
    tok_left = tok_left - 4'd1;
    flag_bits = flag_bits << 1;
    ph = (tok_left == 4'd0) ? PH_FLAG : PH_TOKEN;
  endfunction

  function automatic void decode_word(input logic [7:0] b, input logic st);
    int n0;
    int len;
    logic [12:0] ref_dist;
    bit fin;
    out_word_t r;
    n0 = expect_q.size();
    if (st) begin
      ph = skip_hdr ? PH_SKIP : PH_MAGIC;
      hdr_cnt = '0;
      flag_bits = '0;
      tok_left = '0;
      remaining = '0;
      produced = '0;
      ref_hi = '0;
      halted = 1'b0;
      wr_ptr = '0;
      n_streams++;
    end
    if (!halted) begin
      case (ph)
        PH_SKIP: begin
          hdr_cnt = hdr_cnt + 3'd1;
          if (hdr_cnt >= SKIP_BYTES) begin
            hdr_cnt = '0;
            ph = PH_MAGIC;
          end
        end
        PH_MAGIC: begin
          if (b != magic) begin
            r.value = 8'h00;
            r.kind = KIND_MAGIC;
            r.last = 1'b0;
            r.done = 1'b0;
            expect_q.insert(expect_q.size(), r);
            halted = 1'b1;
            n_bad_type++;
          end else begin
            hdr_cnt = '0;
            remaining = '0;
            ph = PH_LEN;
          end
        end
        PH_LEN: begin
          remaining = remaining | (24'(b) << (8 * hdr_cnt[1:0]));
          hdr_cnt = hdr_cnt + 3'd1;
          if (hdr_cnt >= LEN_BYTES) begin
            hdr_cnt = '0;
            ph = (remaining != 24'd0) ? PH_FLAG : PH_DONE;
            if (remaining == 24'd0) n_empty++;
          end
        end
        PH_FLAG: begin
          flag_bits = b;
          tok_left = TOKENS_PER_FLAG;
          ph = PH_TOKEN;
        end
        PH_TOKEN: begin
          if (flag_bits[7]) begin
            ref_hi = b;
            ph = PH_REFLO;
          end else if (!emit_byte(b)) begin
            next_token();
          end
        end
        PH_REFLO: begin
          ref_dist = {1'b0, ref_hi[3:0], b} + 13'd1;
          len = int'(ref_hi[7:4]) + MIN_MATCH;
          if (ref_dist > produced) begin
            r.value = 8'h00;
            r.kind = KIND_REF;
            r.last = 1'b0;
            r.done = 1'b0;
            expect_q.insert(expect_q.size(), r);
            halted = 1'b1;
            n_early_ref++;
          end else begin
            fin = 1'b0;
            n_copies++;
            for (int j = 0; j < len && !fin; j++) begin
              fin = emit_byte(window[wr_ptr - ref_dist[11:0]]);
            end
            if (!fin) next_token();
          end
        end
        default: begin
        end
      endcase
    end
    if (expect_q.size() > n0) expect_q[expect_q.size() - 1].last = 1'b1;
  endfunction

  task automatic note_failure(input string what);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s", what);
  endtask

  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      decode_word(in_tdata, in_tuser);
      words_accepted++;
    end
    if (!(in_tvalid && !in_tready)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_q.size() != 0 && send_idle && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 2);
        in_tvalid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        next_w = pending_q.pop_front();
        in_tdata <= next_w.data;
        in_tuser <= next_w.start;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      words_out++;
      if (expect_q.size() == 0) begin
        note_failure($sformatf("output word %0d: unexpected byte %02h kind %0d last %0b done %0b",
                               words_out, out_tdata, out_tuser[1:0], out_tlast, out_tuser[2]));
      end else begin
        exp_w = expect_q.pop_front();
        if (out_tdata !== exp_w.value || out_tuser[1:0] !== exp_w.kind ||
            out_tlast !== exp_w.last || out_tuser[2] !== exp_w.done) begin
          note_failure($sformatf({"output word %0d: expected byte %02h kind %0d last %0b ",
                                  "done %0b, got byte %02h kind %0d last %0b done %0b"},
                                 words_out, exp_w.value, exp_w.kind, exp_w.last, exp_w.done,
                                 out_tdata, out_tuser[1:0], out_tlast, out_tuser[2]));
        end
      end
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_on && hold_cnt < HOLD_CYCLES) begin
      hold_cnt++;
      out_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_tready <= 1'b0;
    end else if (recv_idle && $urandom_range(0, 4) == 0) begin
      recv_gap = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic put_word(input logic [7:0] d, input logic s);
    in_word_t w;
    if (cut_left == 0) return;
    if (cut_left > 0) cut_left--;
    w.data = d;
    w.start = s;
    pending_q.insert(pending_q.size(), w);
    words_queued++;
    if (tally) gen_words++;
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_SKIP_IDX) skip_hdr = val[0];
    else magic = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (words_accepted != words_queued || expect_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Builds one compressed stream for the current register values. Distances
  // never reach past the bytes already produced, except for the one early
  // reference that bad_ref asks for.
  task automatic build_stream(input int total, input int ref_pct, input bit far,
                              input bit bad_type, input bit bad_ref, input int cut);
    logic [7:0] toks[$];
    logic [7:0] flag;
    int made;
    int len;
    int ref_dist;
    int span;
    int bad_at;
    bit stop;
    bit is_ref;
    made = 0;
    stop = 1'b0;
    cut_left = cut;
    bad_at = (total > 0) ? int'($urandom_range(0, total - 1)) : 0;
    if (skip_hdr) begin
      put_word(8'($urandom), 1'b1);
      repeat (3) put_word(8'($urandom), 1'b0);
    end
    if (bad_type) begin
      put_word(magic ^ 8'($urandom_range(1, 255)), !skip_hdr);
      cut_left = -1;
      return;
    end
    put_word(magic, !skip_hdr);
    put_word(8'(total), 1'b0);
    put_word(8'(total >> 8), 1'b0);
    put_word(8'(total >> 16), 1'b0);
    while (made < total && !stop) begin
      toks.delete();
      flag = 8'h00;
      for (int t = 7; t >= 0; t--) begin
        is_ref = 1'b0;
        if (made >= total || stop) begin
          flag[t] = 1'($urandom_range(0, 1));
        end else if (bad_ref && made >= bad_at && made < WINDOW) begin
          ref_dist = $urandom_range(made + 1, WINDOW);
          len = $urandom_range(3, 18);
          is_ref = 1'b1;
          stop = 1'b1;
        end else if (made > 0 && $urandom_range(0, 99) < ref_pct) begin
          span = (made < WINDOW) ? made : WINDOW;
          if (far) begin
            len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(3, 18)) : 18;
            ref_dist = (made >= WINDOW && $urandom_range(0, 1) == 0) ? WINDOW
                     : int'($urandom_range(1, span));
          end else begin
            len = $urandom_range(3, 18);
            ref_dist = ($urandom_range(0, 1) == 0)
                     ? int'($urandom_range(1, (span < 4) ? span : 4))
                     : int'($urandom_range(1, span));
          end
          is_ref = 1'b1;
          made += len;
        end else begin
          flag[t] = 1'b0;
          toks.insert(toks.size(), 8'($urandom));
          made++;
        end
        if (is_ref) begin
          flag[t] = 1'b1;
          toks.insert(toks.size(), 8'(((len - 3) << 4) | ((ref_dist - 1) >> 8)));
          toks.insert(toks.size(), 8'(ref_dist - 1));
        end
      end
      put_word(flag, 1'b0);
      foreach (toks[i]) put_word(toks[i], 1'b0);
    end
    cut_left = -1;
  endtask

  task automatic run_phase(input int upto);
    int total;
    int sel;
    while (gen_words < upto) begin
      sel = $urandom_range(0, 19);
      if ($urandom_range(0, 7) == 0) begin
        tally = 1'b0;
        repeat ($urandom_range(1, 4)) put_word(8'($urandom), $urandom_range(0, 3) == 0);
        tally = 1'b1;
      end
      if ($urandom_range(0, 19) == 0) total = 0;
      else if ($urandom_range(0, 4) == 0) total = $urandom_range(41, 160);
      else total = $urandom_range(1, 40);
      build_stream(total, $urandom_range(20, 70), $urandom_range(0, 4) == 0, sel < 2,
                   sel == 2 || sel == 3,
                   (sel == 4 || sel == 5) ? int'($urandom_range(1, 12)) : -1);
      if ($urandom_range(0, 3) == 0) begin
        tally = 1'b0;
        repeat ($urandom_range(1, 2)) put_word(8'($urandom), 1'b0);
        tally = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_idle <= 1'b1;
    recv_idle <= 1'b1;

    // Words before any start are dropped.
    put_word(8'h10, 1'b0);
    put_word(8'hFF, 1'b0);
    // Length three: a literal, then an overlapping copy that is cut short.
    put_word(MAGIC_RESET, 1'b1);
    put_word(8'd3, 1'b0);
    put_word(8'd0, 1'b0);
    put_word(8'd0, 1'b0);
    put_word(8'h40, 1'b0);
    put_word(8'hFF, 1'b0);
    put_word(8'h00, 1'b0);
    put_word(8'h00, 1'b0);
    put_word(8'h00, 1'b0);
    put_word(8'hAA, 1'b0);
    // Zero length, then a word after completion.
    put_word(MAGIC_RESET, 1'b1);
    put_word(8'd0, 1'b0);
    put_word(8'd0, 1'b0);
    put_word(8'd0, 1'b0);
    put_word(8'h55, 1'b0);
    // Wrong type byte.
    put_word(8'hEF, 1'b1);
    put_word(MAGIC_RESET, 1'b0);
    // Full-scale length and a reference before any output.
    put_word(MAGIC_RESET, 1'b1);
    put_word(8'hFF, 1'b0);
    put_word(8'hFF, 1'b0);
    put_word(8'hFF, 1'b0);
    put_word(8'h80, 1'b0);
    put_word(8'hFF, 1'b0);
    put_word(8'hFF, 1'b0);
    settle();

    gen_words = 0;
    write_reg(CFG_SKIP_IDX, 8'd1);
    write_reg(CFG_MAGIC_IDX, 8'h00);
    run_phase(150);
    settle();

    write_reg(CFG_SKIP_IDX, 8'd0);
    write_reg(CFG_MAGIC_IDX, 8'hFF);
    hold_on <= 1'b1;
    run_phase(300);
    settle();

    write_reg(CFG_SKIP_IDX, 8'd1);
    write_reg(CFG_MAGIC_IDX, 8'($urandom_range(1, 254)));
    send_idle <= 1'b0;
    run_phase(390);
    settle();

    write_reg(CFG_SKIP_IDX, 8'd0);
    write_reg(CFG_MAGIC_IDX, MAGIC_RESET);
    recv_idle <= 1'b0;
    run_phase(460);
    settle();
    repeat (40) @(posedge clk);

    if (expect_q.size() != 0) begin
      fail_cnt += expect_q.size();
      $display("%0d expected output words never arrived.", expect_q.size());
    end
    $display("Streams started: %0d, completed: %0d, empty: %0d, bad type: %0d, early refs: %0d.",
             n_streams, n_done, n_empty, n_bad_type, n_early_ref);
    $display("Input words: %0d, output words: %0d, copies: %0d.",
             words_accepted, words_out, n_copies);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Mismatches: %0d", fail_cnt);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
